[rtl/simplex_noise_2d_unit_assert.svh]
// Assertion macros for the simplex noise unit.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SIMPLEX_NOISE_2D_UNIT_ASSERT_SVH
`define SIMPLEX_NOISE_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define SNX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SNX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/snx2d_pkg.sv]
// Shared types, constants and helper functions for the simplex noise unit.
// No dependencies.
`timescale 1ns / 1ps
package snx2d_pkg;

  localparam int PERM_ENTRIES = 256;
  localparam int PERM_AW      = 8;
  localparam int WF           = 30;   // internal fraction bits

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_EVAL = 1'b1;

  // skew / unskew factors in Q30
  localparam logic [28:0] F2_Q = 29'd393016785;
  localparam logic [27:0] G2_Q = 28'd226908346;

  typedef logic        [PERM_AW-1:0] perm_t;
  typedef logic signed [31:0]        coord_t;
  typedef logic signed [15:0]        noise_t;

  // p mod 12 for an 8-bit p: quotient by reciprocal (171/2048), then subtract
  function automatic logic [3:0] hash_mod12(input logic [7:0] p);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = p * 8'd171;
    q    = prod[15:11];
    r    = p - 8'(q) * 8'd12;
    return r[3:0];
  endfunction

  // gradient . offset for the 12-gradient set
  function automatic logic signed [33:0] grad_dot(input logic [3:0] g,
                                                  input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
    logic signed [33:0] xe;
    logic signed [33:0] ye;
    logic signed [33:0] d;
    xe = {{2{x[31]}}, x};
    ye = {{2{y[31]}}, y};
    case (g)
      4'd0:          d = xe + ye;
      4'd1:          d = ye - xe;
      4'd2:          d = xe - ye;
      4'd3:          d = -xe - ye;
      4'd4, 4'd6:    d = xe;
      4'd5, 4'd7:    d = -xe;
      4'd8, 4'd10:   d = ye;
      4'd9, 4'd11:   d = -ye;
      default:       d = '0;
    endcase
    return d;
  endfunction

endpackage

[rtl/snx2d_if.sv]
// Valid/ready channel interfaces for the simplex noise unit.
// Depends on snx2d_pkg.
`timescale 1ns / 1ps
interface snx2d_in_if;
  import snx2d_pkg::*;
  logic   valid;
  logic   ready;
  logic   cmd;
  perm_t  perm_index;
  perm_t  perm_value;
  coord_t x_coord;
  coord_t y_coord;
  modport source (output valid, cmd, perm_index, perm_value, x_coord, y_coord,
                  input ready);
  modport sink   (input valid, cmd, perm_index, perm_value, x_coord, y_coord,
                  output ready);
endinterface

interface snx2d_out_if;
  import snx2d_pkg::*;
  logic   valid;
  logic   ready;
  noise_t noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

[rtl/simplex_noise_2d_unit.sv]
// Simplex noise 2D unit: 12-stage pipeline around replicated permutation memories.
// Depends on snx2d_pkg, snx2d_if, simplex_noise_2d_unit_assert.svh.
//
//  channel  | dir | fields                                     | beat
//  in_ch    | in  | cmd perm_index perm_value x_coord y_coord  | valid & ready
//  out_ch   | out | noise_value                                | valid & ready
//
// One item per cycle while no result is held at the output; each evaluate beat gives one result.
// Loads travel the pipe and write each table copy at the stage that reads it, so
// table updates land in item order. Three copies cover the five reads per point.
// A result held at the output stalls the whole pipe; a bubble anywhere keeps going.
// Reset is synchronous and clears only the stage valid bits; the table is not cleared.
`timescale 1ns / 1ps
`include "simplex_noise_2d_unit_assert.svh"
module simplex_noise_2d_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  snx2d_in_if.sink    in_ch,
  snx2d_out_if.source out_ch
);
  import snx2d_pkg::*;

  localparam int FS = COORD_FRAC_BITS + WF;  // lsb of the cell index in skewed coords
  localparam logic signed [63:0] T_HALF = 64'sh0800_0000_0000_0000;  // 0.5 in Q60

  logic en;
  logic in_fire;
  logic [11:1] ev_r;
  logic [4:1]  ld_r;
  logic        out_valid_r;
  noise_t      out_noise_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r        <= '0;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ev_r        <= {ev_r[10:1], in_fire && (in_ch.cmd == CMD_EVAL)};
      ld_r        <= {ld_r[3:1],  in_fire && (in_ch.cmd == CMD_LOAD)};
      out_valid_r <= ev_r[11];
    end
  end

  // stage 1: capture
  coord_t x1_r, y1_r;
  perm_t  idx1_r, val1_r, idx2_r, val2_r, idx3_r, val3_r, idx4_r, val4_r;

  // stage 2: shared skew product
  logic signed [32:0] sum1;
  logic signed [62:0] pf;
  coord_t             x2_r, y2_r;
  logic signed [62:0] pf2_r;

  assign sum1 = {x1_r[31], x1_r} + {y1_r[31], y1_r};
  assign pf   = sum1 * $signed({1'b0, F2_Q});

  // stage 3: skewed coordinates
  logic signed [63:0] skx3_r, sky3_r;
  perm_t              ii3, jj3, jj3p;
  logic [29:0]        fx3, fy3;
  logic [30:0]        fsum3;
  logic [58:0]        csp3;

  assign ii3   = skx3_r[FS +: PERM_AW];
  assign jj3   = sky3_r[FS +: PERM_AW];
  assign jj3p  = jj3 + 8'd1;
  assign fx3   = skx3_r[FS-1:COORD_FRAC_BITS];
  assign fy3   = sky3_r[FS-1:COORD_FRAC_BITS];
  assign fsum3 = {1'b0, fx3} + {1'b0, fy3};
  assign csp3  = fsum3 * G2_Q;

  // stage 4: unskew, corner offsets, hash addresses
  logic [58:0]        csp4_r;
  logic [29:0]        fx4_r, fy4_r;
  perm_t              ii4_r;
  logic               i14_r;
  perm_t              pa0_r, pa1_r;
  logic signed [31:0] x0, y0;
  logic signed [31:0] ofx [3];
  logic signed [31:0] ofy [3];
  perm_t              ha0, ha1, ha2;

  localparam logic signed [31:0] ONE_Q  = 32'sd1073741824;
  localparam logic signed [31:0] G2_S   = 32'sd226908346;
  localparam logic signed [31:0] G2X2_S = 32'sd453816692;

  always_comb begin
    x0     = $signed({2'b0, fx4_r}) - $signed({3'b0, csp4_r[58:30]});
    y0     = $signed({2'b0, fy4_r}) - $signed({3'b0, csp4_r[58:30]});
    ofx[0] = x0;
    ofy[0] = y0;
    ofx[1] = i14_r ? (x0 - ONE_Q + G2_S) : (x0 + G2_S);
    ofy[1] = i14_r ? (y0 + G2_S) : (y0 - ONE_Q + G2_S);
    ofx[2] = x0 - ONE_Q + G2X2_S;
    ofy[2] = y0 - ONE_Q + G2X2_S;
    ha0    = ii4_r + pa0_r;
    ha1    = ii4_r + 8'(i14_r) + (i14_r ? pa0_r : pa1_r);
    ha2    = ii4_r + 8'd1 + pa1_r;
  end

  // stage 5: hashes back, squares and gradient dots
  logic signed [31:0] ox5_r [3];
  logic signed [31:0] oy5_r [3];
  perm_t              hb5_r [3];
  logic signed [63:0] sqx [3];
  logic signed [63:0] sqy [3];
  logic signed [33:0] dot5 [3];

  // stages 6..11
  logic signed [63:0] sqx6_r [3];
  logic signed [63:0] sqy6_r [3];
  logic signed [33:0] dot6_r [3];
  logic signed [33:0] dot7_r [3];
  logic signed [33:0] dot8_r [3];
  logic signed [33:0] dot9_r [3];
  logic signed [63:0] t6 [3];
  logic [29:0]        t30 [3];
  logic [29:0]        t7_r [3];
  logic [59:0]        tt7 [3];
  logic [59:0]        tt8_r [3];
  logic [57:0]        q8 [3];
  logic [57:0]        q9_r [3];
  logic signed [61:0] c9 [3];
  logic signed [61:0] c10_r [3];
  logic signed [33:0] n10;
  logic signed [33:0] n11_r;
  logic signed [41:0] sc11;
  logic signed [26:0] v11;
  noise_t             sat11;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqx[k]  = ox5_r[k] * ox5_r[k];
      sqy[k]  = oy5_r[k] * oy5_r[k];
      dot5[k] = grad_dot(hash_mod12(hb5_r[k]), ox5_r[k], oy5_r[k]);
      t6[k]   = T_HALF - sqx6_r[k] - sqy6_r[k];
      t30[k]  = t6[k][63] ? 30'd0 : t6[k][59:30];
      tt7[k]  = t7_r[k] * t7_r[k];
      q8[k]   = tt8_r[k][58:30] * tt8_r[k][58:30];
      c9[k]   = $signed({1'b0, q9_r[k][56:30]}) * dot9_r[k];
    end
    n10 = {{2{c10_r[0][61]}}, c10_r[0][61:30]} + {{2{c10_r[1][61]}}, c10_r[1][61:30]}
        + {{2{c10_r[2][61]}}, c10_r[2][61:30]};
    sc11 = n11_r * 42'sd70 + 42'sd16384;
    v11  = sc11[41:15];
    if (v11 > 27'sd32767) begin
      sat11 = 16'sd32767;
    end else if (v11 < -27'sd32767) begin
      sat11 = -16'sd32767;
    end else begin
      sat11 = v11[15:0];
    end
  end

  // permutation table copies
  perm_t mem_a [PERM_ENTRIES];
  perm_t mem_b [PERM_ENTRIES];
  perm_t mem_c [PERM_ENTRIES];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_r[3]) begin
        mem_a[idx3_r] <= val3_r;
      end
      pa0_r <= mem_a[jj3];
      pa1_r <= mem_a[jj3p];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_r[4]) begin
        mem_b[idx4_r] <= val4_r;
        mem_c[idx4_r] <= val4_r;
      end
      hb5_r[0] <= mem_b[ha0];
      hb5_r[1] <= mem_b[ha1];
      hb5_r[2] <= mem_c[ha2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= in_ch.x_coord;
      y1_r   <= in_ch.y_coord;
      idx1_r <= in_ch.perm_index;
      val1_r <= in_ch.perm_value;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      pf2_r  <= pf;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      skx3_r <= {{2{x2_r[31]}}, x2_r, 30'b0} + {pf2_r[62], pf2_r};
      sky3_r <= {{2{y2_r[31]}}, y2_r, 30'b0} + {pf2_r[62], pf2_r};
      idx3_r <= idx2_r;
      val3_r <= val2_r;
      csp4_r <= csp3;
      fx4_r  <= fx3;
      fy4_r  <= fy3;
      ii4_r  <= ii3;
      i14_r  <= (fx3 > fy3);
      idx4_r <= idx3_r;
      val4_r <= val3_r;
      for (int k = 0; k < 3; k++) begin
        ox5_r[k]  <= ofx[k];
        oy5_r[k]  <= ofy[k];
        sqx6_r[k] <= sqx[k];
        sqy6_r[k] <= sqy[k];
        dot6_r[k] <= dot5[k];
        t7_r[k]   <= t30[k];
        dot7_r[k] <= dot6_r[k];
        tt8_r[k]  <= tt7[k];
        dot8_r[k] <= dot7_r[k];
        q9_r[k]   <= q8[k];
        dot9_r[k] <= dot8_r[k];
        c10_r[k]  <= c9[k];
      end
      n11_r       <= n10;
      out_noise_r <= sat11;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_noise_r;

  `SNX_ASSERT_NXT(a_stall_holds, !en, $stable(ev_r) && $stable(ld_r), "pipe moved during stall")
  `SNX_ASSERT_IMP(a_ld_ev_excl, 1'b1, (ld_r & ev_r[4:1]) == 4'd0, "stage holds load and eval")
  `SNX_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(ev_r[11]), "result without evaluate")
  `SNX_ASSERT_IMP(a_sat_range, out_valid_r, out_noise_r != 16'sh8000, "noise below saturation")

endmodule

[tb/simplex_noise_2d_unit_test.sv]
// Testbench for simplex_noise_2d_unit: loads the permutation table, then runs directed
// and random evaluate/load beats, with random idling on both channels in the random part.
// Depends on snx2d_pkg, snx2d_if and the unit RTL.
`timescale 1ns / 1ps
module simplex_noise_2d_unit_test;
  import snx2d_pkg::*;

  class noise_scoreboard;
    perm_t       perm_tbl [PERM_ENTRIES];
    noise_t      noise_q [$];
    int unsigned errors;

    function automatic int grad_x(int g);
      return (g < 8) ? (g[0] ? -1 : 1) : 0;
    endfunction

    function automatic int grad_y(int g);
      if (g < 4) return g[1] ? -1 : 1;
      if (g < 8) return 0;
      return g[0] ? -1 : 1;
    endfunction

    // falloff-weighted gradient term of one corner, Q30
    function automatic longint corner_term(int g, longint dx, longint dy);
      longint t, t2, t4, dot;
      t = (longint'(1) <<< 59) - dx * dx - dy * dy;
      if (t < 0) return 0;
      t   = t >>> 30;
      t2  = (t * t) >>> 30;
      t4  = (t2 * t2) >>> 30;
      dot = grad_x(g) * dx + grad_y(g) * dy;
      return (t4 * dot) >>> 30;
    endfunction

    function automatic perm_t lookup(int idx);
      return perm_tbl[idx & 8'hFF];
    endfunction

    function automatic noise_t noise_at(coord_t xc, coord_t yc);
      longint x, y, s, skx, sky, fx, fy, cs, x0, y0, x1, y1, x2, y2, n, v;
      longint one, g2q, fmask;
      int ci, cj, i1, j1, h0, h1, h2;
      one   = longint'(1) <<< 30;
      g2q   = 226908346;
      fmask = (longint'(1) <<< 46) - 1;
      x   = xc;
      y   = yc;
      s   = x + y;
      skx = x * one + s * 393016785;
      sky = y * one + s * 393016785;
      ci  = int'((skx >>> 46) & 255);
      cj  = int'((sky >>> 46) & 255);
      fx  = (skx & fmask) >> 16;
      fy  = (sky & fmask) >> 16;
      cs  = ((fx + fy) * g2q) >>> 30;
      x0  = fx - cs;
      y0  = fy - cs;
      if (x0 > y0) begin
        i1 = 1; j1 = 0;
      end else begin
        i1 = 0; j1 = 1;
      end
      x1 = x0 - i1 * one + g2q;
      y1 = y0 - j1 * one + g2q;
      x2 = x0 - one + 2 * g2q;
      y2 = y0 - one + 2 * g2q;
      h0 = lookup(ci + lookup(cj)) % 12;
      h1 = lookup(ci + i1 + lookup(cj + j1)) % 12;
      h2 = lookup(ci + 1 + lookup(cj + 1)) % 12;
      n  = corner_term(h0, x0, y0) + corner_term(h1, x1, y1) + corner_term(h2, x2, y2);
      v  = (70 * n + (longint'(1) <<< 14)) >>> 15;
      if (v > 32767) v = 32767;
      if (v < -32767) v = -32767;
      return noise_t'(v);
    endfunction

    function void note_input(logic cmd, perm_t idx, perm_t val, coord_t xc, coord_t yc);
      if (cmd == CMD_LOAD) perm_tbl[idx] = val;
      else noise_q.push_back(noise_at(xc, yc));
    endfunction

    function void check_result(noise_t got);
      noise_t want;
      if (noise_q.size() == 0) begin
        $error("noise_value: unexpected beat, actual %0d", got);
        errors++;
        return;
      end
      want = noise_q.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  noise_scoreboard noise_sb;

  snx2d_in_if  in_if ();
  snx2d_out_if out_if ();

  simplex_noise_2d_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20ns * 500000);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= idle_on ? ($urandom_range(99) >= 24) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) noise_sb.check_result(out_if.noise_value);
  end

  task automatic send_beat(logic cmd, perm_t idx, perm_t val, coord_t xc, coord_t yc);
    while (idle_on && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.perm_index <= idx;
    in_if.perm_value <= val;
    in_if.x_coord    <= xc;
    in_if.y_coord    <= yc;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    noise_sb.note_input(cmd, idx, val, xc, yc);
  endtask

  task automatic send_eval(coord_t xc, coord_t yc);
    send_beat(CMD_EVAL, perm_t'($urandom), perm_t'($urandom), xc, yc);
  endtask

  task automatic send_load(perm_t idx, perm_t val);
    send_beat(CMD_LOAD, idx, val, coord_t'($urandom), coord_t'($urandom));
  endtask

  // mostly small coordinates where the cells vary; some full-range ones
  function automatic coord_t rand_coord();
    if ($urandom_range(3) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(32'h0040_0000)) - coord_t'(32'h0020_0000);
  endfunction

  initial begin
    perm_t  shuffled [PERM_ENTRIES];
    coord_t corners [6];
    int     k, pick;
    perm_t  tmp;
    noise_sb         = new();
    idle_on          = 1'b0;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cmd        <= CMD_LOAD;
    in_if.perm_index <= '0;
    in_if.perm_value <= '0;
    in_if.x_coord    <= '0;
    in_if.y_coord    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table with a shuffled permutation so every read is defined
    for (k = 0; k < PERM_ENTRIES; k++) shuffled[k] = perm_t'(k);
    for (k = PERM_ENTRIES - 1; k > 0; k--) begin
      pick = $urandom_range(k);
      tmp = shuffled[k]; shuffled[k] = shuffled[pick]; shuffled[pick] = tmp;
    end
    for (k = 0; k < PERM_ENTRIES; k++) send_load(perm_t'(k), shuffled[k]);

    // directed: field extremes, cell edges, load field extremes
    corners = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh1, 32'sh0001_0000};
    for (k = 0; k < 18; k++) send_eval(corners[k % 6], corners[(k / 3) % 6]);
    send_load(8'h00, 8'hFF);
    send_load(8'hFF, 8'h00);
    send_load(8'hFF, 8'hFF);
    send_eval(32'sh0000_8000, 32'sh0000_4000);
    send_eval(32'sh0003_2000, -32'sh0002_7000);

    // random: mostly evaluates, some table rewrites; long calm stretch first
    for (k = 0; k < 2000; k++) begin
      if (k == 300) idle_on = 1'b1;
      if (k == 1000) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (noise_sb.noise_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 15) send_load(perm_t'($urandom), perm_t'($urandom));
      else send_eval(rand_coord(), rand_coord());
    end
    in_if.valid <= 1'b0;

    while (noise_sb.noise_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (noise_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/snx2d_pkg.sv
rtl/snx2d_if.sv
rtl/simplex_noise_2d_unit.sv
tb/simplex_noise_2d_unit_test.sv
